// File: src/ep2cal_pkg.sv
// ----------------------------------------------------------------------------
// ep2cal_pkg: constants for the epoch seconds to calendar converter
// Calendar offsets, reciprocal multipliers for the constant divides, and the
// month start table of the date recovery.
// ----------------------------------------------------------------------------
package ep2cal_pkg;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;

    // JDN at the epoch plus the Richards offset, folded into one add
    localparam int unsigned JDN_AT_EPOCH    = 2440588;
    localparam int unsigned RICHARDS_OFFSET = 32044;
    localparam int unsigned A_OFFSET        = JDN_AT_EPOCH + RICHARDS_OFFSET;

    localparam int unsigned DAYS_400Y = 146097;
    localparam int unsigned DAYS_4Y   = 1461;
    localparam int unsigned MON_DAYS5 = 153;

    // year - 4800 - 2000, only the low byte survives
    localparam int unsigned YEAR_TOTAL_OFFSET = 4800 + 2000;

    // JDN mod 7 = (days + JDN_AT_EPOCH) mod 7
    localparam int unsigned WEEK_OFFSET = JDN_AT_EPOCH % 7;

    // Exact reciprocals: m = ceil(2^s / d), s = input bits + ceil(log2 d)
    localparam int unsigned DAY_SH = 35;  // (secs >> 7) / 675, 25-bit input
    localparam int unsigned B_SH   = 42;  // (4a + 3) / 146097, 24-bit input
    localparam int unsigned HR_SH  = 21;  // (tod >> 4) / 225, 13-bit input
    localparam int unsigned WK_SH  = 19;  // days / 7, 16-bit input
    localparam int unsigned D_SH   = 31;  // (4c + 3) / 1461, 20-bit input
    localparam int unsigned MN_SH  = 14;  // (rem >> 2) / 15, 10-bit input
    localparam int unsigned M_SH   = 19;  // (5e + 2) / 153, 11-bit input

    localparam logic [25:0] M_DAY = 26'(((64'd1 << DAY_SH) + 64'd674) / 64'd675);
    localparam logic [24:0] M_B   = 25'(((64'd1 << B_SH) + 64'd146096) / 64'd146097);
    localparam logic [13:0] M_HR  = 14'(((64'd1 << HR_SH) + 64'd224) / 64'd225);
    localparam logic [16:0] M_WK  = 17'(((64'd1 << WK_SH) + 64'd6) / 64'd7);
    localparam logic [20:0] M_D   = 21'(((64'd1 << D_SH) + 64'd1460) / 64'd1461);
    localparam logic [10:0] M_MN  = 11'(((64'd1 << MN_SH) + 64'd14) / 64'd15);
    localparam logic [11:0] M_M   = 12'(((64'd1 << M_SH) + 64'd152) / 64'd153);

    localparam int unsigned N_STAGES = 8;

    // (153 * m + 2) / 5 for the shifted month index m (March = 0)
    function automatic logic [8:0] month_base(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/epoch_seconds_to_calendar_core.sv
// Throughput: one word per cycle while i_stall is low; each stage holds one word and fills bubbles.
// Stage depth is set by one constant-reciprocal multiply or one subtract per stage.
// Reset (synchronous, active low) clears only the stage valid bits.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core: Unix seconds to Gregorian date and time
// Eight-stage pipeline: day split, Julian day, Richards date recovery,
// weekday and time of day. All divides are exact reciprocal multiplies.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core
    import ep2cal_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_year_offset,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day_of_month,
    output logic [2:0]  o_weekday,
    output logic [4:0]  o_hour,
    output logic [5:0]  o_minute,
    output logic [5:0]  o_second
);

    // ------------------------------------------------------------------
    // Flow control: a stage loads when empty or when the next one loads.
    // ------------------------------------------------------------------
    logic [N_STAGES:1] r_vld;
    logic [N_STAGES:1] stg_rdy;

    always_comb begin
        stg_rdy[N_STAGES] = !r_vld[N_STAGES] || !i_stall;
        for (int k = N_STAGES - 1; k >= 1; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
    end

    assign o_stall = !stg_rdy[1];
    assign o_valid = r_vld[N_STAGES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= N_STAGES; k++) begin
                if (stg_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: day quotient multiply. 86400 = 128 * 675.
    // ------------------------------------------------------------------
    logic [31:0] r1_secs;
    logic [50:0] r1_pday;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r1_secs <= i_epoch_seconds;
            r1_pday <= 51'(i_epoch_seconds[31:7]) * 51'(M_DAY);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: day count and time of day
    // ------------------------------------------------------------------
    logic [15:0] s2_days;
    logic [16:0] s2_tod;
    logic [15:0] r2_days;
    logic [16:0] r2_tod;

    assign s2_days = r1_pday[DAY_SH +: 16];
    assign s2_tod  = 17'(r1_secs - 32'(s2_days) * 32'(SECS_PER_DAY));

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r2_days <= s2_days;
            r2_tod  <= s2_tod;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: Richards a, 400-year multiply, hour and weekday multiplies
    // ------------------------------------------------------------------
    logic [21:0] s3_a;
    logic [21:0] r3_a;
    logic [48:0] r3_pb;
    logic [26:0] r3_phr;
    logic [32:0] r3_pwk;
    logic [16:0] r3_tod;
    logic [15:0] r3_days;

    assign s3_a = 22'(32'(r2_days) + 32'(A_OFFSET));

    always_ff @(posedge i_clk) begin
        if (stg_rdy[3]) begin
            r3_a    <= s3_a;
            r3_pb   <= 49'({s3_a, 2'b11}) * 49'(M_B);     // 4a + 3
            r3_phr  <= 27'(r2_tod[16:4]) * 27'(M_HR);     // 3600 = 16 * 225
            r3_pwk  <= 33'(r2_days) * 33'(M_WK);
            r3_tod  <= r2_tod;
            r3_days <= r2_days;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: b, c, hour, seconds into the hour, weekday
    // ------------------------------------------------------------------
    logic [6:0]  s4_b;
    logic [23:0] s4_bprod;
    logic [17:0] s4_c;
    logic [4:0]  s4_hr;
    logic [11:0] s4_rem;
    logic [13:0] s4_q7;
    logic [3:0]  s4_r7;
    logic [3:0]  s4_wsum;
    logic [2:0]  s4_wd;

    assign s4_b     = r3_pb[B_SH +: 7];
    assign s4_bprod = 24'(s4_b) * 24'(DAYS_400Y);
    assign s4_c     = 18'(r3_a - 22'(s4_bprod >> 2));
    assign s4_hr    = r3_phr[HR_SH +: 5];
    assign s4_rem   = 12'(r3_tod - 17'(s4_hr) * 17'(SECS_PER_HOUR));
    assign s4_q7    = r3_pwk[WK_SH +: 14];
    assign s4_r7    = 4'(r3_days - 16'(s4_q7) * 16'd7);
    assign s4_wsum  = s4_r7 + 4'(WEEK_OFFSET);
    assign s4_wd    = (s4_wsum >= 4'd7) ? 3'(s4_wsum - 4'd7) : 3'(s4_wsum);

    logic [17:0] r4_c;
    logic [6:0]  r4_b;
    logic [4:0]  r4_hr;
    logic [11:0] r4_rem;
    logic [2:0]  r4_wd;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[4]) begin
            r4_c   <= s4_c;
            r4_b   <= s4_b;
            r4_hr  <= s4_hr;
            r4_rem <= s4_rem;
            r4_wd  <= s4_wd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: 4-year multiply and minute multiply (60 = 4 * 15)
    // ------------------------------------------------------------------
    logic [40:0] r5_pd;
    logic [20:0] r5_pmn;
    logic [17:0] r5_c;
    logic [6:0]  r5_b;
    logic [4:0]  r5_hr;
    logic [11:0] r5_rem;
    logic [2:0]  r5_wd;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[5]) begin
            r5_pd  <= 41'({r4_c, 2'b11}) * 41'(M_D);       // 4c + 3
            r5_pmn <= 21'(r4_rem[11:2]) * 21'(M_MN);
            r5_c   <= r4_c;
            r5_b   <= r4_b;
            r5_hr  <= r4_hr;
            r5_rem <= r4_rem;
            r5_wd  <= r4_wd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: d, e, partial year, minute and second
    // ------------------------------------------------------------------
    logic [8:0]  s6_d;
    logic [20:0] s6_dprod;
    logic [8:0]  s6_e;
    logic [5:0]  s6_mn;
    logic [5:0]  s6_sc;
    logic [12:0] s6_ybd;

    assign s6_d     = r5_pd[D_SH +: 9];
    assign s6_dprod = 21'(s6_d) * 21'(DAYS_4Y);
    assign s6_e     = 9'(r5_c - 18'(s6_dprod >> 2));
    assign s6_mn    = r5_pmn[MN_SH +: 6];
    assign s6_sc    = 6'(r5_rem - 12'(s6_mn) * 12'(SECS_PER_MIN));
    assign s6_ybd   = 13'(r5_b) * 13'd100 + 13'(s6_d);

    logic [8:0]  r6_e;
    logic [12:0] r6_ybd;
    logic [4:0]  r6_hr;
    logic [5:0]  r6_mn;
    logic [5:0]  r6_sc;
    logic [2:0]  r6_wd;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[6]) begin
            r6_e   <= s6_e;
            r6_ybd <= s6_ybd;
            r6_hr  <= r5_hr;
            r6_mn  <= s6_mn;
            r6_sc  <= s6_sc;
            r6_wd  <= r5_wd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: month index multiply
    // ------------------------------------------------------------------
    logic [10:0] s7_xm;
    logic [22:0] r7_pm;
    logic [8:0]  r7_e;
    logic [12:0] r7_ybd;
    logic [4:0]  r7_hr;
    logic [5:0]  r7_mn;
    logic [5:0]  r7_sc;
    logic [2:0]  r7_wd;

    assign s7_xm = 11'(r6_e) * 11'd5 + 11'd2;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[7]) begin
            r7_pm  <= 23'(s7_xm) * 23'(M_M);
            r7_e   <= r6_e;
            r7_ybd <= r6_ybd;
            r7_hr  <= r6_hr;
            r7_mn  <= r6_mn;
            r7_sc  <= r6_sc;
            r7_wd  <= r6_wd;
        end
    end

    // ------------------------------------------------------------------
    // Stage 8 (output register): month, day of month, year offset.
    // Index m counts from March; Jan and Feb (m >= 10) roll into next year.
    // ------------------------------------------------------------------
    logic [3:0] s8_m;
    logic       s8_hi;
    logic [8:0] s8_base;
    logic [4:0] s8_mday;
    logic [3:0] s8_mon;
    logic [7:0] s8_yr;

    assign s8_m    = r7_pm[M_SH +: 4];
    assign s8_hi   = (s8_m >= 4'd10);
    assign s8_base = month_base(s8_m);
    assign s8_mday = 5'(r7_e - s8_base + 9'd1);
    assign s8_mon  = s8_hi ? (s8_m - 4'd9) : (s8_m + 4'd3);
    assign s8_yr   = r7_ybd[7:0] + {7'd0, s8_hi} - 8'(YEAR_TOTAL_OFFSET);

    logic [7:0] r8_yr;
    logic [3:0] r8_mon;
    logic [4:0] r8_mday;
    logic [2:0] r8_wd;
    logic [4:0] r8_hr;
    logic [5:0] r8_mn;
    logic [5:0] r8_sc;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[8]) begin
            r8_yr   <= s8_yr;
            r8_mon  <= s8_mon;
            r8_mday <= s8_mday;
            r8_wd   <= r7_wd;
            r8_hr   <= r7_hr;
            r8_mn   <= r7_mn;
            r8_sc   <= r7_sc;
        end
    end

    assign o_year_offset  = r8_yr;
    assign o_month        = r8_mon;
    assign o_day_of_month = r8_mday;
    assign o_weekday      = r8_wd;
    assign o_hour         = r8_hr;
    assign o_minute       = r8_mn;
    assign o_second       = r8_sc;

endmodule
